// ===== src/hcbd_pkg.sv =====
`default_nettype none

package hcbd_pkg;

  localparam int DEFAULT_SIZE_BITS = 32;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       body_end;
    logic       terminal_seen;
  } out_word_t;

endpackage

`default_nettype wire

// ===== src/hcbd_parse.sv =====
`default_nettype none

module hcbd_parse import hcbd_pkg::*; #(
  parameter int SIZE_BITS = DEFAULT_SIZE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire in_word_t  step_word,
  output logic           res_valid,
  output out_word_t      res_word
);

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_HEX  = 3'd1,
    PH_EXT  = 3'd2,
    PH_CR   = 3'd3,
    PH_DATA = 3'd4,
    PH_TCR  = 3'd5,
    PH_TLF  = 3'd6,
    PH_STOP = 3'd7
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;

  logic                 is_hex;
  logic [3:0]           hex_val;

  // hex digit decode, either case
  always_comb begin
    is_hex  = 1'b1;
    hex_val = '0;
    if (step_word.body_byte >= "0" && step_word.body_byte <= "9") begin
      hex_val = 4'(step_word.body_byte - 8'("0"));
    end else if (step_word.body_byte >= "a" && step_word.body_byte <= "f") begin
      hex_val = 4'(step_word.body_byte - 8'("a") + 8'd10);
    end else if (step_word.body_byte >= "A" && step_word.body_byte <= "F") begin
      hex_val = 4'(step_word.body_byte - 8'("A") + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // phases only move forward within one byte, so the fall-through chain is
  // evaluated once in order: TCR, TLF, LEAD, HEX, EXT, CR, DATA
  always_comb begin
    logic [7:0] b;
    logic       done;
    logic       dvalid;
    b         = step_word.body_byte;
    done      = 1'b0;
    dvalid    = 1'b0;
    phase_nxt = phase_r;
    count_nxt = count_r;

    if (phase_r == PH_TCR) begin
      phase_nxt = PH_TLF;
      done      = (b == CHAR_CR);
    end
    if (!done && phase_nxt == PH_TLF) begin
      phase_nxt = PH_LEAD;
      done      = (b == CHAR_LF);
    end
    if (!done && phase_nxt == PH_LEAD) begin
      if (b == CHAR_SP || b == CHAR_TAB) done = 1'b1;
      else phase_nxt = PH_HEX;
    end
    if (!done && phase_nxt == PH_HEX) begin
      if (is_hex) begin
        count_nxt = {count_r[SIZE_BITS-5:0], hex_val};
        done      = 1'b1;
      end else begin
        phase_nxt = PH_EXT;
      end
    end
    if (!done && phase_nxt == PH_EXT) begin
      done = 1'b1;
      if (b == CHAR_NUL) begin
        phase_nxt = PH_STOP;
      end else if (b == CHAR_CR) begin
        if (step_word.body_last) phase_nxt = (count_r == '0) ? PH_STOP : PH_DATA;
        else phase_nxt = PH_CR;
      end else if (b == CHAR_LF) begin
        phase_nxt = (count_r == '0) ? PH_STOP : PH_DATA;
      end
    end
    if (!done && phase_nxt == PH_CR) begin
      phase_nxt = (count_r == '0) ? PH_STOP : PH_DATA;
      done      = (b == CHAR_LF);
    end
    if (!done && phase_nxt == PH_DATA) begin
      dvalid    = 1'b1;
      count_nxt = count_r - SIZE_BITS'(1);
      if (count_nxt == '0) phase_nxt = PH_TCR;
    end

    res_word.data_byte     = dvalid ? b : 8'h00;
    res_word.data_valid    = dvalid;
    res_word.body_end      = step_word.body_last;
    res_word.terminal_seen = (phase_nxt == PH_STOP);
    res_valid = step_en && (dvalid || step_word.body_last ||
                (phase_nxt == PH_STOP && phase_r != PH_STOP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      count_r <= '0;
    end else if (step_en) begin
      if (step_word.body_last) begin
        phase_r <= PH_LEAD;
        count_r <= '0;
      end else begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/http_chunked_body_decoder.sv =====
`default_nettype none

// HTTP chunked body decoder. Raw body bytes go in on the in_ channel
// (body_last marks the final byte); only chunk payload comes out on the out_
// channel, plus a word for the last body byte and one where a zero-size chunk
// (or a NUL in a size line) stops decoding. Throughput is one byte per clock
// while in_stall is low: the phase machine and the chunk counter update in
// the same cycle the byte is taken, and the result is registered in the
// output register, or the spare if out_stall holds it. A two-entry skid
// (output register plus one spare) keeps in_stall a pure register: it rises
// only when the spare holds a word because out_stall held the output. After
// body_last the decoder returns to its reset state, ready for the next body.
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int SIZE_BITS = DEFAULT_SIZE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      in_take;
  logic      res_valid;
  out_word_t res_word;

  logic      out_valid_r, skid_valid_r;
  out_word_t out_word_r, skid_word_r;
  logic      out_free;

  assign in_take = in_valid && !in_stall;

  hcbd_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_take),
    .step_word (in_word),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // output register drains or is empty
  assign out_free = !out_valid_r || !out_stall;

  // in_stall == skid full, so a new result never meets a full skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          out_word_r   <= skid_word_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= res_valid;
          if (res_valid) out_word_r <= res_word;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
        skid_word_r  <= res_word;
      end
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== src/hcbd_checker.sv =====
`default_nettype none

module hcbd_props import hcbd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // payload never comes after decoding stopped
  a_data_not_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.data_valid |-> !out_word.terminal_seen)
    else $error("payload byte flagged terminal");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.data_valid |-> out_word.data_byte == 8'h00)
    else $error("non-payload word carries a data byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffers not empty after reset");

  // an accepted last byte always yields a word, so input can't run on idle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.body_last && !out_valid |=> out_valid)
    else $error("last body byte gave no result");

endmodule

bind http_chunked_body_decoder hcbd_props u_hcbd_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

// ===== verif/hcbd_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the chunked body decoder, predicts the decoded
// words from the accepted body bytes and compares them in order.
module hcbd_checker import hcbd_pkg::*; #(
  parameter int SIZE_BITS = DEFAULT_SIZE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending
);

  typedef enum logic [2:0] {
    LEAD_WS,
    SIZE_DIGITS,
    SIZE_EXT,
    SIZE_CR,
    PAYLOAD,
    TRAIL_CR,
    TRAIL_LF,
    STOPPED
  } decode_phase_t;

  decode_phase_t        phase       = LEAD_WS;
  logic [SIZE_BITS-1:0] chunk_count = '0;
  out_word_t            decoded_q[$];
  int                   mismatches  = 0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void close_size_line();
    phase = (chunk_count == '0) ? STOPPED : PAYLOAD;
  endfunction

  // Returns 1 when the byte produces an output word.
  function automatic bit decode_byte(input in_word_t w, output out_word_t res);
    logic [7:0] b;
    bit         redo;
    bit         passed;
    bit         was_stopped;
    bit         stopped;
    int         digit;
    b           = w.body_byte;
    passed      = 1'b0;
    was_stopped = (phase == STOPPED);
    redo        = 1'b1;
    while (redo) begin
      redo = 1'b0;
      case (phase)
        LEAD_WS: begin
          if (b != CHAR_SP && b != CHAR_TAB) begin
            phase = SIZE_DIGITS;
            redo  = 1'b1;
          end
        end
        SIZE_DIGITS: begin
          digit = hex_digit(b);
          if (digit >= 0) begin
            chunk_count = {chunk_count[SIZE_BITS-5:0], digit[3:0]};
          end else begin
            phase = SIZE_EXT;
            redo  = 1'b1;
          end
        end
        SIZE_EXT: begin
          if (b == CHAR_NUL) begin
            phase = STOPPED;
          end else if (b == CHAR_CR) begin
            // CR on the last byte completes the line right away
            if (w.body_last) close_size_line();
            else phase = SIZE_CR;
          end else if (b == CHAR_LF) begin
            close_size_line();
          end
        end
        SIZE_CR: begin
          // lone CR: the byte is reprocessed, as payload unless the size was zero
          close_size_line();
          redo = (b != CHAR_LF);
        end
        PAYLOAD: begin
          passed      = 1'b1;
          chunk_count = chunk_count - SIZE_BITS'(1);
          if (chunk_count == '0) phase = TRAIL_CR;
        end
        TRAIL_CR: begin
          phase = TRAIL_LF;
          redo  = (b != CHAR_CR);
        end
        TRAIL_LF: begin
          phase = LEAD_WS;
          redo  = (b != CHAR_LF);
        end
        default: ;
      endcase
    end
    stopped           = (phase == STOPPED);
    res.data_byte     = passed ? b : 8'h00;
    res.data_valid    = passed;
    res.body_end      = w.body_last;
    res.terminal_seen = stopped;
    if (w.body_last) begin
      phase       = LEAD_WS;
      chunk_count = '0;
    end
    return passed || w.body_last || (stopped && !was_stopped);
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      phase       = LEAD_WS;
      chunk_count = '0;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("output word with nothing expected: %p", out_word);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("data_byte", want.data_byte, out_word.data_byte);
          compare_field("data_valid", 8'(want.data_valid), 8'(out_word.data_valid));
          compare_field("body_end", 8'(want.body_end), 8'(out_word.body_end));
          compare_field("terminal_seen", 8'(want.terminal_seen),
                        8'(out_word.terminal_seen));
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(in_word, want)) decoded_q.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= decoded_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Top: drives chunked bodies into the decoder with random gaps, stalls the
// output side at random, and gives the verdict from the checker's counts.
module testbench;
  import hcbd_pkg::*;

  localparam int BODY_ITEMS   = 1600;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int LONG_HOLD    = 80;    // receiver hold-off, long enough to fill the skid
  localparam int LONG_HOLD_AT = 150;   // output word count that triggers it
  localparam int SETTLE       = 20;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  in_word_t   in_word     = '0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  out_word_t  out_word;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         sent_count  = 0;
  int         recv_count  = 0;
  bit         send_burst  = 1'b0;   // no gaps between input words while set
  bit         recv_burst  = 1'b0;   // no stalls on the output while set
  bit         mid_drained = 1'b0;
  logic [7:0] body_q[$];            // bytes of the body being built
  string      hex_text    = "0123456789abcdefABCDEF";

  http_chunked_body_decoder i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_word,
    .out_valid,
    .out_stall,
    .out_word
  );

  hcbd_checker i_checker (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_word,
    .out_valid,
    .out_stall,
    .out_word,
    .fail_count,
    .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one word and hold it until the decoder takes it. The gap before
  // it is random unless in a burst; valid stays high across back-to-back
  // words so it is never lowered and raised in the same step.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Send the built body, body_last on its final byte, and clear it.
  task automatic send_body();
    in_word_t w;
    foreach (body_q[i]) begin
      w.body_byte = body_q[i];
      w.body_last = (i == body_q.size() - 1);
      send_word(w);
    end
    body_q.delete();
  endtask

  // Input goes quiet until every predicted word has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed chunked bodies with random content; some are cut
  // short, and some are plain noise weighted toward the framing bytes.
  task automatic make_random_body();
    int         kind;
    int         size;
    int         keep;
    int         choice;
    string      digits;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 16)) begin
        case ($urandom_range(0, 7))
          0: c = CHAR_NUL;
          1: c = CHAR_CR;
          2: c = CHAR_LF;
          3: c = CHAR_SP;
          4: c = CHAR_TAB;
          5: c = "0";
          6: c = "a";
          default: c = 8'($urandom_range(0, 255));
        endcase
        body_q.push_back(c);
      end
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) body_q.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
      if ($urandom_range(0, 39) == 0) begin
        // oversized size field: the count wraps at its width
        repeat ($urandom_range(9, 12)) body_q.push_back(hex_text[$urandom_range(0, 21)]);
        size = $urandom_range(2, 6);
      end else begin
        size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if ($urandom_range(0, 4) == 0) body_q.push_back("0");
        digits = $sformatf("%0h", size);
        foreach (digits[i]) begin
          c = digits[i];
          if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
          body_q.push_back(c);
        end
      end
      // chunk extension; anything but NUL, CR and LF
      if ($urandom_range(0, 3) == 0) begin
        body_q.push_back(";");
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(1, 255)); while (c == CHAR_CR || c == CHAR_LF);
          body_q.push_back(c);
        end
      end
      // line end: CRLF, bare LF, or lone CR
      choice = $urandom_range(0, 5);
      if (choice != 4) body_q.push_back(CHAR_CR);
      if (choice <= 4) body_q.push_back(CHAR_LF);
      repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
      // trailer after the payload: CRLF, CR, LF or nothing
      choice = $urandom_range(0, 5);
      if (choice <= 3) body_q.push_back(CHAR_CR);
      if (choice <= 2 || choice == 4) body_q.push_back(CHAR_LF);
    end
    // last chunk, maybe a trailer header, then the closing blank line
    body_q.push_back("0");
    body_q.push_back(CHAR_CR);
    body_q.push_back(CHAR_LF);
    if ($urandom_range(0, 1)) begin
      body_q.push_back("X");
      body_q.push_back(":");
      body_q.push_back("1");
      body_q.push_back(CHAR_CR);
      body_q.push_back(CHAR_LF);
    end
    body_q.push_back(CHAR_CR);
    body_q.push_back(CHAR_LF);
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > keep) void'(body_q.pop_back());
    end
  endtask

  // Sender.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // lone CR, then 0xff and NUL as payload; LF ends a zero size line
    body_q = '{CHAR_TAB, "2", CHAR_CR, 8'hff, CHAR_NUL, "0", CHAR_LF, "z"};
    send_body();
    // NUL inside a size line stops decoding
    body_q = '{"1", ";", CHAR_NUL, "q"};
    send_body();
    // empty size line
    body_q = '{CHAR_CR, CHAR_LF};
    send_body();
    // body ends inside the payload
    body_q = '{"B", CHAR_CR, CHAR_LF, "a", "b"};
    send_body();
    // body ends inside a size line
    body_q = '{CHAR_SP, "f", "F"};
    send_body();
    // CR on the last byte completes a zero size line
    body_q = '{"0", CHAR_CR};
    send_body();
    wait_for_drain();

    while (sent_count < BODY_ITEMS) begin
      send_burst = ($urandom_range(0, 3) == 0);
      make_random_body();
      send_body();
      if (!mid_drained && sent_count >= BODY_ITEMS / 2) begin
        mid_drained = 1'b1;
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending != 0) $error("%0d predicted words never came out", pending);
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stall before each word, burst stretches with none,
  // and one long hold-off so the decoder backs up into in_stall.
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, 7);
      if (recv_count == LONG_HOLD_AT) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      recv_count++;
      if (recv_count % 64 == 0) recv_burst = ($urandom_range(0, 2) == 0);
    end
  end

endmodule
